[rtl/sbp_pkg.sv]
// shared constants and types for the size-prefixed block parser
package sbp_pkg;

  localparam int SIZE_WIDTH    = 32;
  localparam int INDEX_WIDTH   = 16;
  localparam int MAX_SIZE_LINE = 18;
  localparam int LINE_WIDTH    = 5;

  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    EV_PAYLOAD = 2'd0,
    EV_BLOCK   = 2'd1,
    EV_MESSAGE = 2'd2,
    EV_ERROR   = 2'd3
  } event_t;

endpackage

[rtl/sbp_in_if.sv]
// input stream channel: kind and byte with valid/ready
interface sbp_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] byte_in;

  modport source (output valid, output kind, output byte_in, input ready);
  modport sink (input valid, input kind, input byte_in, output ready);
endinterface

[rtl/sbp_out_if.sv]
// event channel: parser results with valid/ready
interface sbp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic [7:0]  payload_byte;
  logic [15:0] block_index;
  logic [31:0] block_size;

  modport source (output valid, output event_res, output payload_byte,
                  output block_index, output block_size, input ready);
  modport sink (input valid, input event_res, input payload_byte,
                input block_index, input block_size, output ready);
endinterface

[rtl/size_prefixed_block_parser.sv]
// size-prefixed block parser: decodes size lines, payload and terminators
// an input transaction reaches the event output through the input register, then the result register
// throughput: one byte per cycle; the parse state updates in a single step per byte
// stalls only when the result register holds an event not yet taken
// reset (rst, synchronous): parser back to block start, counters cleared, both stages empty
module size_prefixed_block_parser (
  input  logic clk,
  input  logic rst,
  sbp_in_if.sink    stream,
  sbp_out_if.source events
);

  typedef enum logic [2:0] {
    PH_START    = 3'd0,
    PH_BLANK_CR = 3'd1,
    PH_SIZE     = 3'd2,
    PH_PAYLOAD  = 3'd3,
    PH_TERM     = 3'd4,
    PH_TERM_LF  = 3'd5,
    PH_ERROR    = 3'd6
  } phase_t;

  localparam int SW = sbp_pkg::SIZE_WIDTH;
  localparam int IW = sbp_pkg::INDEX_WIDTH;
  localparam int LW = sbp_pkg::LINE_WIDTH;
  localparam logic [LW-1:0] LINE_LIMIT = LW'(sbp_pkg::MAX_SIZE_LINE);
  localparam logic [SW+3:0] SIZE_MASK  = {4'b0, {SW{1'b1}}};

  // input register
  logic       in_valid;
  logic       kind;
  logic [7:0] byte_q;

  // parse state
  phase_t          phase, phase_next;
  logic [SW-1:0]   size_accum, size_accum_next;
  logic [LW-1:0]   line_length, line_length_next;
  logic [SW-1:0]   bytes_remaining, bytes_remaining_next;
  logic [IW-1:0]   block_counter, block_counter_next;
  logic            digits_done, digits_done_next;

  // result register
  logic             out_valid;
  sbp_pkg::event_t  event_res;
  logic [7:0]       payload_byte;
  logic [15:0]      block_index;
  logic [31:0]      block_size;

  logic             res_valid;
  sbp_pkg::event_t  res_event;
  logic [7:0]       res_byte;
  logic [63:0]      res_index_wide;
  logic [63:0]      res_size_wide;

  logic            advance;
  logic            is_digit;
  logic [SW+3:0]   size_ext;
  logic [SW+3:0]   size_times_ten;

  assign advance      = !out_valid || events.ready;
  assign stream.ready = !in_valid || advance;

  assign is_digit       = (byte_q >= sbp_pkg::CH_ZERO) && (byte_q <= sbp_pkg::CH_NINE);
  assign size_ext       = {4'b0, size_accum};
  assign size_times_ten = (size_ext << 3) + (size_ext << 1) + {{SW{1'b0}}, byte_q[3:0]};

  always_comb begin
    phase_next           = phase;
    size_accum_next      = size_accum;
    line_length_next     = line_length;
    bytes_remaining_next = bytes_remaining;
    block_counter_next   = block_counter;
    digits_done_next     = digits_done;
    res_valid            = 1'b0;
    res_event            = sbp_pkg::EV_PAYLOAD;
    res_byte             = 8'd0;
    res_index_wide       = 64'(block_counter);
    res_size_wide        = 64'd0;

    if (kind == sbp_pkg::KIND_CLEAR) begin
      phase_next           = PH_START;
      size_accum_next      = '0;
      line_length_next     = '0;
      bytes_remaining_next = '0;
      block_counter_next   = '0;
      digits_done_next     = 1'b0;
    end else begin
      case (phase)
        PH_START: begin
          if (byte_q == sbp_pkg::CH_LF) begin
            block_counter_next = '0;
            res_valid          = 1'b1;
            res_event          = sbp_pkg::EV_MESSAGE;
          end else if (byte_q == sbp_pkg::CH_CR) begin
            phase_next = PH_BLANK_CR;
          end else if (!is_digit) begin
            phase_next = PH_ERROR;
            res_valid  = 1'b1;
            res_event  = sbp_pkg::EV_ERROR;
          end else begin
            size_accum_next  = SW'(byte_q[3:0]);
            line_length_next = LW'(1);
            digits_done_next = 1'b0;
            phase_next       = PH_SIZE;
          end
        end
        PH_BLANK_CR: begin
          if (byte_q == sbp_pkg::CH_LF) begin
            block_counter_next = '0;
            phase_next         = PH_START;
            res_valid          = 1'b1;
            res_event          = sbp_pkg::EV_MESSAGE;
          end else begin
            phase_next = PH_ERROR;
            res_valid  = 1'b1;
            res_event  = sbp_pkg::EV_ERROR;
          end
        end
        PH_SIZE: begin
          if (byte_q == sbp_pkg::CH_LF) begin
            bytes_remaining_next = size_accum;
            phase_next           = (size_accum == '0) ? PH_TERM : PH_PAYLOAD;
          end else if (line_length >= LINE_LIMIT) begin
            phase_next = PH_ERROR;
            res_valid  = 1'b1;
            res_event  = sbp_pkg::EV_ERROR;
          end else begin
            line_length_next = line_length + LW'(1);
            if (!digits_done) begin
              if (is_digit) begin
                if (size_times_ten > SIZE_MASK) begin
                  phase_next = PH_ERROR;
                  res_valid  = 1'b1;
                  res_event  = sbp_pkg::EV_ERROR;
                end else begin
                  size_accum_next = size_times_ten[SW-1:0];
                end
              end else begin
                digits_done_next = 1'b1;
              end
            end
          end
        end
        PH_PAYLOAD: begin
          bytes_remaining_next = bytes_remaining - SW'(1);
          if (bytes_remaining == SW'(1)) begin
            phase_next = PH_TERM;
          end
          res_valid     = 1'b1;
          res_event     = sbp_pkg::EV_PAYLOAD;
          res_byte      = byte_q;
          res_size_wide = 64'(size_accum);
        end
        PH_TERM, PH_TERM_LF: begin
          if (byte_q == sbp_pkg::CH_LF) begin
            block_counter_next = block_counter + IW'(1);
            phase_next         = PH_START;
            res_valid          = 1'b1;
            res_event          = sbp_pkg::EV_BLOCK;
            res_size_wide      = 64'(size_accum);
          end else if (byte_q == sbp_pkg::CH_CR && phase == PH_TERM) begin
            phase_next = PH_TERM_LF;
          end else begin
            phase_next = PH_ERROR;
            res_valid  = 1'b1;
            res_event  = sbp_pkg::EV_ERROR;
          end
        end
        default: begin
          phase_next = PH_ERROR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid        <= 1'b0;
      out_valid       <= 1'b0;
      phase           <= PH_START;
      size_accum      <= '0;
      line_length     <= '0;
      bytes_remaining <= '0;
      block_counter   <= '0;
      digits_done     <= 1'b0;
    end else begin
      if (stream.ready) begin
        in_valid <= stream.valid;
        kind     <= stream.kind;
        byte_q   <= stream.byte_in;
      end
      if (advance) begin
        out_valid    <= in_valid && res_valid;
        event_res    <= res_event;
        payload_byte <= res_byte;
        block_index  <= res_index_wide[15:0];
        block_size   <= res_size_wide[31:0];
      end
      if (in_valid && advance) begin
        phase           <= phase_next;
        size_accum      <= size_accum_next;
        line_length     <= line_length_next;
        bytes_remaining <= bytes_remaining_next;
        block_counter   <= block_counter_next;
        digits_done     <= digits_done_next;
      end
    end
  end

  assign events.valid        = out_valid;
  assign events.event_res    = event_res;
  assign events.payload_byte = payload_byte;
  assign events.block_index  = block_index;
  assign events.block_size   = block_size;

endmodule

[test/testbench.sv]
// self-checking testbench for the size-prefixed block parser
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 800;

  typedef enum logic [2:0] {
    AT_BLOCK_START,
    AT_BLANK_CR,
    IN_SIZE_LINE,
    IN_PAYLOAD,
    AT_TERMINATOR,
    AT_TERMINATOR_LF,
    IN_ERROR
  } parse_phase_t;

  typedef struct {
    sbp_pkg::event_t                 ev;
    logic [7:0]                      data;
    logic [sbp_pkg::INDEX_WIDTH-1:0] index;
    logic [sbp_pkg::SIZE_WIDTH-1:0]  size;
  } parser_event_t;

  logic clk = 1'b0;
  logic rst;

  sbp_in_if  stream_if ();
  sbp_out_if event_if ();

  size_prefixed_block_parser dut (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_if),
    .events (event_if)
  );

  always #10 clk = ~clk;

  parse_phase_t                    parser_phase  = AT_BLOCK_START;
  logic [sbp_pkg::SIZE_WIDTH-1:0]  declared_size = '0;
  logic [sbp_pkg::LINE_WIDTH-1:0]  line_length   = '0;
  logic [sbp_pkg::SIZE_WIDTH-1:0]  bytes_left    = '0;
  logic [sbp_pkg::INDEX_WIDTH-1:0] block_count   = '0;
  logic                            digits_ended  = 1'b0;

  parser_event_t pending_events[$];
  int  mismatches   = 0;
  int  parsed_items = 0;
  int  cycle_count  = 0;
  bit  gaps_on      = 1'b1;
  bit  hold_request = 1'b0;

  function automatic void push_event(sbp_pkg::event_t ev, logic [7:0] data,
                                     logic [sbp_pkg::INDEX_WIDTH-1:0] index,
                                     logic [sbp_pkg::SIZE_WIDTH-1:0] size);
    parser_event_t e;
    e.ev    = ev;
    e.data  = data;
    e.index = index;
    e.size  = size;
    pending_events.push_back(e);
  endfunction

  function automatic void enter_error();
    parser_phase = IN_ERROR;
    push_event(sbp_pkg::EV_ERROR, 8'h00, block_count, '0);
  endfunction

  function automatic void close_block();
    push_event(sbp_pkg::EV_BLOCK, 8'h00, block_count, declared_size);
    block_count  = block_count + 1'b1;
    parser_phase = AT_BLOCK_START;
  endfunction

  function automatic void end_message();
    push_event(sbp_pkg::EV_MESSAGE, 8'h00, block_count, '0);
    block_count  = '0;
    parser_phase = AT_BLOCK_START;
  endfunction

  function automatic void predict_parse(logic kind, logic [7:0] b);
    logic                             is_digit;
    logic [sbp_pkg::SIZE_WIDTH-1:0]   digit;
    logic [sbp_pkg::SIZE_WIDTH+3:0]   grown;
    is_digit = (b >= sbp_pkg::CH_ZERO) && (b <= sbp_pkg::CH_NINE);
    digit    = sbp_pkg::SIZE_WIDTH'(b - sbp_pkg::CH_ZERO);
    if (kind == sbp_pkg::KIND_CLEAR) begin
      parser_phase  = AT_BLOCK_START;
      declared_size = '0;
      line_length   = '0;
      bytes_left    = '0;
      block_count   = '0;
      digits_ended  = 1'b0;
      return;
    end
    case (parser_phase)
      AT_BLOCK_START: begin
        if (b == sbp_pkg::CH_LF) begin
          end_message();
        end else if (b == sbp_pkg::CH_CR) begin
          parser_phase = AT_BLANK_CR;
        end else if (!is_digit) begin
          enter_error();
        end else begin
          declared_size = digit;
          line_length   = 1;
          digits_ended  = 1'b0;
          parser_phase  = IN_SIZE_LINE;
        end
      end
      AT_BLANK_CR: begin
        if (b == sbp_pkg::CH_LF) begin
          end_message();
        end else begin
          enter_error();
        end
      end
      IN_SIZE_LINE: begin
        if (b == sbp_pkg::CH_LF) begin
          bytes_left   = declared_size;
          parser_phase = (declared_size == 0) ? AT_TERMINATOR : IN_PAYLOAD;
        end else if (line_length >= sbp_pkg::MAX_SIZE_LINE) begin
          enter_error();
        end else begin
          line_length = line_length + 1'b1;
          if (!digits_ended) begin
            if (is_digit) begin
              grown = {4'b0, declared_size} * 10 + digit;
              if (grown[sbp_pkg::SIZE_WIDTH+3:sbp_pkg::SIZE_WIDTH] != 0) begin
                enter_error();
              end else begin
                declared_size = grown[sbp_pkg::SIZE_WIDTH-1:0];
              end
            end else begin
              digits_ended = 1'b1;
            end
          end
        end
      end
      IN_PAYLOAD: begin
        push_event(sbp_pkg::EV_PAYLOAD, b, block_count, declared_size);
        bytes_left = bytes_left - 1'b1;
        if (bytes_left == 0) begin
          parser_phase = AT_TERMINATOR;
        end
      end
      AT_TERMINATOR: begin
        if (b == sbp_pkg::CH_LF) begin
          close_block();
        end else if (b == sbp_pkg::CH_CR) begin
          parser_phase = AT_TERMINATOR_LF;
        end else begin
          enter_error();
        end
      end
      AT_TERMINATOR_LF: begin
        if (b == sbp_pkg::CH_LF) begin
          close_block();
        end else begin
          enter_error();
        end
      end
      default: begin
        parser_phase = IN_ERROR;
      end
    endcase
  endfunction

  // event checker
  always @(posedge clk) begin
    parser_event_t e;
    if (!rst && event_if.valid && event_if.ready) begin
      if (pending_events.size() == 0) begin
        $error("unexpected event %0d", event_if.event_res);
        mismatches++;
      end else begin
        e = pending_events.pop_front();
        if (event_if.event_res !== e.ev) begin
          $error("event_res expected %0d got %0d", e.ev, event_if.event_res);
          mismatches++;
        end
        if (event_if.payload_byte !== e.data) begin
          $error("payload_byte expected %0h got %0h", e.data, event_if.payload_byte);
          mismatches++;
        end
        if (event_if.block_index !== e.index) begin
          $error("block_index expected %0d got %0d", e.index, event_if.block_index);
          mismatches++;
        end
        if (event_if.block_size !== e.size) begin
          $error("block_size expected %0d got %0d", e.size, event_if.block_size);
          mismatches++;
        end
      end
    end
  end

  // receiver ready with random stalls and an occasional long hold-off
  always @(negedge clk) begin
    int hold_left;
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      event_if.ready <= 1'b0;
    end else if (gaps_on) begin
      event_if.ready <= ($urandom_range(99) >= 29);
    end else begin
      event_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic send_item(input logic kind, input logic [7:0] b);
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < 29) begin
      stream_if.valid   <= 1'b0;
      stream_if.kind    <= 1'($urandom);
      stream_if.byte_in <= 8'($urandom);
      @(negedge clk);
    end
    stream_if.valid   <= 1'b1;
    stream_if.kind    <= kind;
    stream_if.byte_in <= b;
    @(posedge clk);
    while (!stream_if.ready) @(posedge clk);
    if (parser_phase != IN_ERROR) parsed_items++;
    predict_parse(kind, b);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(sbp_pkg::KIND_DATA, s[i]);
  endtask

  // line end chosen at random between LF and CR LF
  task automatic send_line_end();
    if ($urandom_range(1)) send_item(sbp_pkg::KIND_DATA, sbp_pkg::CH_CR);
    send_item(sbp_pkg::KIND_DATA, sbp_pkg::CH_LF);
  endtask

  task automatic send_clear();
    send_item(sbp_pkg::KIND_CLEAR, 8'($urandom));
  endtask

  task automatic wait_drain();
    @(negedge clk);
    stream_if.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_block();
    int    n;
    string line;
    string tail;
    n    = ($urandom_range(99) < 85) ? $urandom_range(0, 6) : $urandom_range(7, 40);
    line = $sformatf("%0d", n);
    if ($urandom_range(99) < 20) begin
      while (line.len() < sbp_pkg::MAX_SIZE_LINE) line = {"0", line};
    end else if ($urandom_range(99) < 40) begin
      case ($urandom_range(2))
        0:       tail = "\r";
        1:       tail = " x";
        default: tail = ";a9\r";
      endcase
      line = {line, tail};
    end
    send_text({line, "\n"});
    repeat (n) send_item(sbp_pkg::KIND_DATA, 8'($urandom));
    send_line_end();
  endtask

  task automatic random_message();
    repeat ($urandom_range(0, 3)) random_block();
    send_line_end();
  endtask

  task automatic broken_sequence();
    logic [7:0]  b;
    logic [31:0] big;
    string       line;
    case ($urandom_range(7))
      0: begin
        do b = 8'($urandom);
        while ((b >= sbp_pkg::CH_ZERO && b <= sbp_pkg::CH_NINE) ||
               b == sbp_pkg::CH_LF || b == sbp_pkg::CH_CR);
        send_item(sbp_pkg::KIND_DATA, b);
      end
      1: begin
        do b = 8'($urandom); while (b == sbp_pkg::CH_LF);
        send_item(sbp_pkg::KIND_DATA, sbp_pkg::CH_CR);
        send_item(sbp_pkg::KIND_DATA, b);
      end
      2: begin
        send_text({$sformatf("%0d", 64'h1_0000_0000 + 64'($urandom)), "\n"});
      end
      3: begin
        line = "1";
        repeat ($urandom_range(sbp_pkg::MAX_SIZE_LINE, sbp_pkg::MAX_SIZE_LINE + 5)) begin
          line = {line, ($urandom_range(3) == 0) ? "a" : "0"};
        end
        send_text({line, "\n"});
      end
      4: begin
        do b = 8'($urandom); while (b == sbp_pkg::CH_LF || b == sbp_pkg::CH_CR);
        send_text($sformatf("%0d\n", $urandom_range(0, 3)));
        while (parser_phase == IN_PAYLOAD) send_item(sbp_pkg::KIND_DATA, 8'($urandom));
        send_item(sbp_pkg::KIND_DATA, b);
      end
      5: begin
        do b = 8'($urandom); while (b == sbp_pkg::CH_LF);
        send_text("0\n\r");
        send_item(sbp_pkg::KIND_DATA, b);
      end
      6: begin
        big = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : $urandom;
        send_text({$sformatf("%0d", big), "\n"});
        repeat ($urandom_range(1, 4)) send_item(sbp_pkg::KIND_DATA, 8'($urandom));
      end
      default: begin
        send_text("3\nab");
      end
    endcase
    while (parser_phase == IN_ERROR && $urandom_range(99) < 60) begin
      send_item(sbp_pkg::KIND_DATA, 8'($urandom));
    end
    send_clear();
  endtask

  task automatic run_random(input int items);
    int target;
    target = parsed_items + items;
    while (parsed_items < target) begin
      if ($urandom_range(99) < 80) random_message();
      else broken_sequence();
    end
  endtask

  // size line with trailing text, payload extremes, CRLF end, blank line
  task automatic test_basic_message();
    send_text("2 \r\n");
    send_item(sbp_pkg::KIND_DATA, 8'h00);
    send_item(sbp_pkg::KIND_DATA, 8'hFF);
    send_text("\r\n\n");
  endtask

  task automatic test_empty_block();
    send_text("0\n\n\r\n");
  endtask

  task automatic test_bad_start();
    send_text("xy");
    send_item(sbp_pkg::KIND_CLEAR, 8'hFF);
    send_text("\rA");
    send_item(sbp_pkg::KIND_CLEAR, 8'h00);
  endtask

  task automatic test_bad_terminator();
    send_text("1\nzz");
    send_clear();
  endtask

  task automatic test_backpressure();
    gaps_on      = 1'b0;
    hold_request = 1'b1;
    send_text("40\n");
    repeat (40) send_item(sbp_pkg::KIND_DATA, 8'($urandom));
    send_text("\n\n");
    wait_drain();
    gaps_on = 1'b1;
  endtask

  task automatic test_no_gaps();
    gaps_on = 1'b0;
    run_random(150);
    gaps_on = 1'b1;
  endtask

  initial begin
    rst                = 1'b1;
    stream_if.valid    = 1'b0;
    stream_if.kind     = sbp_pkg::KIND_DATA;
    stream_if.byte_in  = 8'h00;
    event_if.ready     = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_basic_message();
    test_empty_block();
    test_bad_start();
    test_bad_terminator();
    wait_drain();
    test_backpressure();
    run_random(RANDOM_ITEMS / 2);
    test_no_gaps();
    run_random(RANDOM_ITEMS - RANDOM_ITEMS / 2 - 150);

    wait_drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
